/* hw/rtl/xcfd_pkg.sv */
// Shared types and constants for the XOR-checked frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package xcfd_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_MAGIC_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAGIC_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD  = 2'd2;

  localparam logic [7:0]  MAGIC_FIRST_RST  = 8'hA5;
  localparam logic [7:0]  MAGIC_SECOND_RST = 8'h5A;
  localparam logic [31:0] MAX_PAYLOAD_RST  = 32'd1024;

  localparam logic [1:0] ST_MORE  = 2'd0;
  localparam logic [1:0] ST_GOOD  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef struct packed {
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [31:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [31:0] payload_index;
    logic [7:0]  frame_kind;
    logic [31:0] frame_length;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/xcfd_parser.sv */
// Frame parser: parse state registers and the per-beat next-state/result logic.
// Depends on xcfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcfd_parser import xcfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire cfg_t       cfg_i,
  output res_t            res_o
);

  localparam logic [2:0] PH_MAGIC1  = 3'd0;
  localparam logic [2:0] PH_MAGIC2  = 3'd1;
  localparam logic [2:0] PH_KIND    = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CHECK   = 3'd5;

  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  len_cnt;
    logic [31:0] len;
    logic [31:0] pcount;
    logic [7:0]  kind;
    logic [7:0]  xsum;
  } pstate_t;

  pstate_t st_q, st_d;
  logic [31:0] assembled;
  logic [31:0] pcount_next;
  logic [7:0]  xsum_in;

  assign assembled   = st_q.len | ({24'd0, rx_byte_i} << {st_q.len_cnt, 3'b000});
  assign pcount_next = st_q.pcount + 32'd1;
  assign xsum_in     = st_q.xsum ^ rx_byte_i;

  always_comb begin
    st_d  = st_q;
    res_o = '0;
    res_o.status = ST_MORE;
    unique case (st_q.phase)
      PH_MAGIC1: begin
        if (rx_byte_i == cfg_i.magic_first) begin
          st_d.xsum  = rx_byte_i;
          st_d.phase = PH_MAGIC2;
        end
      end
      PH_MAGIC2: begin
        if (rx_byte_i == cfg_i.magic_second) begin
          st_d.xsum  = xsum_in;
          st_d.phase = PH_KIND;
        end else begin
          st_d = '0;
          if (rx_byte_i == cfg_i.magic_first) begin
            st_d.xsum  = rx_byte_i;
            st_d.phase = PH_MAGIC2;
          end
        end
      end
      PH_KIND: begin
        st_d.kind    = rx_byte_i;
        st_d.xsum    = xsum_in;
        st_d.len_cnt = 2'd0;
        st_d.len     = '0;
        st_d.phase   = PH_LENGTH;
      end
      PH_LENGTH: begin
        st_d.xsum = xsum_in;
        st_d.len  = assembled;
        if (st_q.len_cnt == 2'd3) begin
          st_d.len_cnt = 2'd0;
          if (assembled > cfg_i.max_payload) begin
            st_d = '0;
            res_o.status = ST_ERROR;
          end else if (assembled != 32'd0) begin
            st_d.pcount = '0;
            st_d.phase  = PH_PAYLOAD;
          end else begin
            st_d.phase = PH_CHECK;
          end
        end else begin
          st_d.len_cnt = st_q.len_cnt + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        st_d.xsum           = xsum_in;
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = rx_byte_i;
        res_o.payload_index = st_q.pcount;
        st_d.pcount         = pcount_next;
        if (pcount_next >= st_q.len) begin
          st_d.phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (rx_byte_i != st_q.xsum) begin
          res_o.status = ST_ERROR;
        end else begin
          res_o.status       = ST_GOOD;
          res_o.frame_kind   = st_q.kind;
          res_o.frame_length = st_q.len;
        end
        st_d = '0;
      end
      default: begin
        st_d = '0;
        res_o.status = ST_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase <= PH_CHECK)
    else $error("parse phase left the legal range");

  a_len_cnt_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.len_cnt != 2'd0) |-> (st_q.phase == PH_LENGTH))
    else $error("length byte count set outside the length phase");

  a_good_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.status == ST_GOOD) |=> (st_q.phase == PH_MAGIC1))
    else $error("parser did not return to hunt after a good frame");

  a_payload_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_PAYLOAD) |-> (st_q.pcount < st_q.len))
    else $error("payload count reached length inside the payload phase");

endmodule

`default_nettype wire

/* hw/rtl/xcfd_skid.sv */
// Two-entry result buffer: output register plus skid register.
// Depends on xcfd_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module xcfd_skid import xcfd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t push_data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      out_data_o
);

  logic out_valid_q;
  logic skid_valid_q;
  res_t out_q;
  res_t skid_q;
  logic out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("beat pushed into a full buffer");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("stalled beat not captured in skid register");

endmodule

`default_nettype wire

/* hw/rtl/xor_checked_frame_deframer.sv */
// Deframer takes one received byte per beat and emits exactly one result beat per byte,
// at a sustained rate of one byte per cycle while in_stall_o is low; each result is
// registered. The parse state update (compare, length shift-in, running XOR, 32-bit length
// compare) is combinational. A two-entry result buffer holds results while the output
// is stalled; in_stall_o rises only when both entries hold results. Configuration
// registers may be written only while no results are outstanding.
// Top level; depends on xcfd_pkg, xcfd_parser and xcfd_skid.
`timescale 1ns / 1ps
`default_nettype none

module xor_checked_frame_deframer import xcfd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          rx_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               status_o,
  output logic                     payload_valid_o,
  output logic [7:0]               payload_byte_o,
  output logic [31:0]              payload_index_o,
  output logic [7:0]               frame_kind_o,
  output logic [31:0]              frame_length_o
);

  cfg_t cfg_q;
  res_t res;
  res_t out_res;
  logic accept;
  logic full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_first  <= MAGIC_FIRST_RST;
      cfg_q.magic_second <= MAGIC_SECOND_RST;
      cfg_q.max_payload  <= MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAGIC_FIRST:  cfg_q.magic_first  <= cfg_wdata_i[7:0];
        CFG_MAGIC_SECOND: cfg_q.magic_second <= cfg_wdata_i[7:0];
        CFG_MAX_PAYLOAD:  cfg_q.max_payload  <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  xcfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  xcfd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign status_o        = out_res.status;
  assign payload_valid_o = out_res.payload_valid;
  assign payload_byte_o  = out_res.payload_byte;
  assign payload_index_o = out_res.payload_index;
  assign frame_kind_o    = out_res.frame_kind;
  assign frame_length_o  = out_res.frame_length;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking bench for xor_checked_frame_deframer: directed table, then random frames and bytes.
// Predicts each result beat (or takes it from the directed table) and compares it against the DUT output stream.
// Depends on xcfd_pkg and the xor_checked_frame_deframer RTL.
`timescale 1ns / 1ps

module testbench;
  import xcfd_pkg::*;

  localparam int DIR_ROWS       = 26;
  localparam int CFG_PHASES     = 5;
  localparam int RAND_PER_PHASE = 315;
  localparam int QUIET_LIMIT    = 5000;
  localparam int HOLD_AT_BEAT   = 700;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 8;

  localparam res_t IDLE_RES = '0;
  localparam res_t ERR_RES  = '{ST_ERROR, 1'b0, 8'h00, 32'd0, 8'h00, 32'd0};

  typedef enum logic [2:0] {
    HUNT_MAGIC1, HUNT_MAGIC2, GET_KIND, GET_LENGTH, GET_PAYLOAD, GET_CHECK
  } phase_e;

  typedef enum int { FLOW, LIGHT, HEAVY, COMB } stall_mode_e;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    res_t       want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_stall_o;
  logic [7:0]          rx_byte;
  logic                out_valid_o;
  logic                out_stall;
  logic [1:0]          status_o;
  logic                payload_valid_o;
  logic [7:0]          payload_byte_o;
  logic [31:0]         payload_index_o;
  logic [7:0]          frame_kind_o;
  logic [31:0]         frame_length_o;

  logic tag_typed;
  res_t tag_want;

  cfg_t       cfg_now;
  phase_e     ph;
  logic [1:0] len_bytes;
  logic [31:0] frame_len;
  logic [31:0] pay_cnt;
  logic [7:0] kind_q;
  logic [7:0] xor_acc;

  res_t results_due [$];
  int   mismatches;
  int   beats_in;
  int   quiet_cycles;
  int   items_sent;
  int   burst_left;
  int   good_seen;
  int   err_seen;
  int   pay_seen;

  xor_checked_frame_deframer DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .status_o        (status_o),
    .payload_valid_o (payload_valid_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .frame_kind_o    (frame_kind_o),
    .frame_length_o  (frame_length_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_parse();
    ph        = HUNT_MAGIC1;
    len_bytes = '0;
    frame_len = '0;
    pay_cnt   = '0;
    kind_q    = '0;
    xor_acc   = '0;
  endfunction

  function automatic res_t deframe_step(input logic [7:0] b);
    res_t r;
    r = '0;
    case (ph)
      HUNT_MAGIC1: begin
        if (b == cfg_now.magic_first) begin
          xor_acc = b;
          ph      = HUNT_MAGIC2;
        end
      end
      HUNT_MAGIC2: begin
        if (b == cfg_now.magic_second) begin
          xor_acc = xor_acc ^ b;
          ph      = GET_KIND;
        end else begin
          restart_parse();
          if (b == cfg_now.magic_first) begin
            xor_acc = b;
            ph      = HUNT_MAGIC2;
          end
        end
      end
      GET_KIND: begin
        kind_q    = b;
        xor_acc   = xor_acc ^ b;
        len_bytes = '0;
        frame_len = '0;
        ph        = GET_LENGTH;
      end
      GET_LENGTH: begin
        xor_acc   = xor_acc ^ b;
        frame_len = frame_len | ({24'd0, b} << (8 * len_bytes));
        if (len_bytes == 2'd3) begin
          len_bytes = '0;
          if (frame_len > cfg_now.max_payload) begin
            restart_parse();
            r.status = ST_ERROR;
          end else if (frame_len != 0) begin
            pay_cnt = '0;
            ph      = GET_PAYLOAD;
          end else begin
            ph = GET_CHECK;
          end
        end else begin
          len_bytes = len_bytes + 2'd1;
        end
      end
      GET_PAYLOAD: begin
        xor_acc         = xor_acc ^ b;
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = pay_cnt;
        pay_cnt         = pay_cnt + 32'd1;
        if (pay_cnt >= frame_len) ph = GET_CHECK;
      end
      GET_CHECK: begin
        if (b != xor_acc) begin
          r.status = ST_ERROR;
        end else begin
          r.status       = ST_GOOD;
          r.frame_kind   = kind_q;
          r.frame_length = frame_len;
        end
        restart_parse();
      end
      default: begin
        restart_parse();
        r.status = ST_ERROR;
      end
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at %0t", what, $realtime);
      $display("  exp st=%0d pv=%0d pb=%02h pi=%0d fk=%02h fl=%0d",
               want.status, want.payload_valid, want.payload_byte,
               want.payload_index, want.frame_kind, want.frame_length);
      $display("  got st=%0d pv=%0d pb=%02h pi=%0d fk=%02h fl=%0d",
               got.status, got.payload_valid, got.payload_byte,
               got.payload_index, got.frame_kind, got.frame_length);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    res_t got;
    res_t want;
    res_t next_res;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        moved = 1'b1;
        got = '{status_o, payload_valid_o, payload_byte_o, payload_index_o,
                frame_kind_o, frame_length_o};
        if (results_due.size() == 0) begin
          note_mismatch("unexpected beat", IDLE_RES, got);
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status || got.payload_valid !== want.payload_valid ||
              got.payload_byte !== want.payload_byte ||
              got.payload_index !== want.payload_index ||
              got.frame_kind !== want.frame_kind ||
              got.frame_length !== want.frame_length) begin
            note_mismatch("field", want, got);
          end
          if (want.status == ST_GOOD) good_seen++;
          if (want.status == ST_ERROR) err_seen++;
          if (want.payload_valid) pay_seen++;
        end
      end
      if (in_valid && !in_stall_o) begin
        moved = 1'b1;
        next_res = deframe_step(rx_byte);
        results_due.push_back(tag_typed ? tag_want : next_res);
        beats_in <= beats_in + 1;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : receiver
    stall_mode_e mode;
    int mode_left;
    int hold_cnt;
    int cyc;
    logic hold_done;
    mode      = FLOW;
    mode_left = 0;
    hold_cnt  = 0;
    cyc       = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          FLOW:    out_stall <= 1'b0;
          LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
          HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= cyc[2];
        endcase
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
    $display("xor_checked_frame_deframer verification failed");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b, input logic typed, input res_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid  <= 1'b1;
    rx_byte   <= b;
    tag_typed <= typed;
    tag_want  <= want;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_frame(input logic corrupt, input logic oversize);
    logic [7:0]  kind;
    logic [31:0] len;
    logic [31:0] cap;
    logic [7:0]  sum;
    logic [7:0]  pb;
    kind = 8'($urandom);
    if (oversize) begin
      len = cfg_now.max_payload + 32'd1 + ($urandom % (32'hFFFF_FFFF - cfg_now.max_payload));
    end else begin
      cap = (cfg_now.max_payload > 12) ? 32'd12 : cfg_now.max_payload;
      if ($urandom_range(0, 19) == 0) begin
        cap = (cfg_now.max_payload > 48) ? 32'd48 : cfg_now.max_payload;
      end
      len = $urandom_range(0, cap);
    end
    sum = cfg_now.magic_first ^ cfg_now.magic_second ^ kind ^
          len[7:0] ^ len[15:8] ^ len[23:16] ^ len[31:24];
    send_beat(cfg_now.magic_first, 1'b0, IDLE_RES);
    send_beat(cfg_now.magic_second, 1'b0, IDLE_RES);
    send_beat(kind, 1'b0, IDLE_RES);
    send_beat(len[7:0], 1'b0, IDLE_RES);
    send_beat(len[15:8], 1'b0, IDLE_RES);
    send_beat(len[23:16], 1'b0, IDLE_RES);
    send_beat(len[31:24], 1'b0, IDLE_RES);
    if (!oversize) begin
      for (int i = 0; i < int'(len); i++) begin
        pb  = 8'($urandom);
        sum = sum ^ pb;
        send_beat(pb, 1'b0, IDLE_RES);
      end
      if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
      send_beat(sum, 1'b0, IDLE_RES);
    end
  endtask

  task automatic program_cfg(input cfg_t c);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MAGIC_FIRST;
    cfg_wdata <= {24'd0, c.magic_first};
    @(posedge clk);
    cfg_idx   <= CFG_MAGIC_SECOND;
    cfg_wdata <= {24'd0, c.magic_second};
    @(posedge clk);
    cfg_idx   <= CFG_MAX_PAYLOAD;
    cfg_wdata <= c.max_payload;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cfg_now = c;
  endtask

  initial begin : stimulus
    dir_row_t dir_tab [DIR_ROWS];
    cfg_t     phase_cfg [CFG_PHASES];
    int       phase_start;
    int       pick;
    int       n;

    dir_tab = '{
      '{8'h00, 1'b1, IDLE_RES},
      '{8'hA5, 1'b0, IDLE_RES},
      '{8'h5A, 1'b0, IDLE_RES},
      '{8'hFF, 1'b0, IDLE_RES},
      '{8'h01, 1'b0, IDLE_RES},
      '{8'h00, 1'b0, IDLE_RES},
      '{8'h00, 1'b0, IDLE_RES},
      '{8'h00, 1'b0, IDLE_RES},
      '{8'hFF, 1'b1, '{ST_MORE, 1'b1, 8'hFF, 32'd0, 8'h00, 32'd0}},
      '{8'hFE, 1'b1, '{ST_GOOD, 1'b0, 8'h00, 32'd0, 8'hFF, 32'd1}},
      '{8'hA5, 1'b0, IDLE_RES},
      '{8'hA5, 1'b1, IDLE_RES},
      '{8'h5A, 1'b0, IDLE_RES},
      '{8'h00, 1'b0, IDLE_RES},
      '{8'h00, 1'b0, IDLE_RES},
      '{8'h00, 1'b0, IDLE_RES},
      '{8'h00, 1'b0, IDLE_RES},
      '{8'h00, 1'b0, IDLE_RES},
      '{8'h00, 1'b1, ERR_RES},
      '{8'hA5, 1'b0, IDLE_RES},
      '{8'h5A, 1'b0, IDLE_RES},
      '{8'h00, 1'b0, IDLE_RES},
      '{8'hFF, 1'b0, IDLE_RES},
      '{8'hFF, 1'b0, IDLE_RES},
      '{8'hFF, 1'b0, IDLE_RES},
      '{8'hFF, 1'b1, ERR_RES}
    };

    phase_cfg[0] = '{8'h00, 8'hFF, 32'd1};
    phase_cfg[1] = '{8'hFF, 8'h00, 32'hFFFF_FFFF};
    phase_cfg[2] = '{8'h3C, 8'h3C, 32'd7};
    phase_cfg[3] = '{8'($urandom), 8'($urandom), 32'($urandom_range(1, 40))};
    phase_cfg[4] = '{MAGIC_FIRST_RST, MAGIC_SECOND_RST, MAX_PAYLOAD_RST};

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_MAGIC_FIRST;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    rx_byte      = '0;
    tag_typed    = 1'b0;
    tag_want     = IDLE_RES;
    mismatches   = 0;
    beats_in     = 0;
    quiet_cycles = 0;
    items_sent   = 0;
    burst_left   = 0;
    good_seen    = 0;
    err_seen     = 0;
    pay_seen     = 0;
    cfg_now      = '{MAGIC_FIRST_RST, MAGIC_SECOND_RST, MAX_PAYLOAD_RST};
    restart_parse();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_beat(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int p = 0; p <= CFG_PHASES; p++) begin
      if (p != 0) program_cfg(phase_cfg[p-1]);
      phase_start = items_sent;
      while (items_sent - phase_start < RAND_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_frame($urandom_range(0, 6) == 0, 1'b0);
        end else if (pick < 78 && cfg_now.max_payload != 32'hFFFF_FFFF) begin
          send_frame(1'b0, 1'b1);
        end else if (pick < 88) begin
          send_beat(cfg_now.magic_first, 1'b0, IDLE_RES);
          n = $urandom_range(1, 4);
          repeat (n) send_beat(8'($urandom), 1'b0, IDLE_RES);
        end else begin
          send_beat(8'($urandom), 1'b0, IDLE_RES);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d input beats over %0d register settings", beats_in, CFG_PHASES + 1);
    $display("saw %0d good frames, %0d frame errors, %0d payload bytes",
             good_seen, err_seen, pay_seen);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("xor_checked_frame_deframer verification clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, results_due.size());
      $display("xor_checked_frame_deframer verification failed");
    end
    $finish;
  end

endmodule
